// ===== rtl/rkt_pkg.sv =====
`default_nettype none

package rkt_pkg;

   // Table depth and the index and counter widths that follow from it.
   localparam int ENTRIES = 16;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W   = $clog2(ENTRIES + 1);
   localparam logic [CNT_W-1:0] ENTRIES_CNT = CNT_W'(ENTRIES);

   // Field widths.
   localparam int MODE_W   = 3;
   localparam int KEY_W    = 64;
   localparam int PID_W    = 31;
   localparam int COUNT_W  = 32;
   localparam int STATUS_W = 2;
   localparam int USED_W   = 5;

   // Beat layouts, rounded up to whole bytes.
   localparam int REQ_FIELDS_W = KEY_W + PID_W + COUNT_W;
   localparam int REQ_TDATA_W  = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = PID_W + COUNT_W + USED_W;
   localparam int RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_TUSER_W  = STATUS_W + 1;

   // Request modes.
   localparam logic [MODE_W-1:0] MODE_INSERT = 3'd0;
   localparam logic [MODE_W-1:0] MODE_INC    = 3'd1;
   localparam logic [MODE_W-1:0] MODE_DEC    = 3'd2;
   localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd3;
   localparam logic [MODE_W-1:0] MODE_LOOKUP = 3'd4;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_PRESENT = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
   localparam logic [STATUS_W-1:0] ST_MISSING = 2'd3;

   // One stored record, valid flag included.
   typedef struct packed {
      logic               valid;
      logic [KEY_W-1:0]   key;
      logic [PID_W-1:0]   pid;
      logic [COUNT_W-1:0] refs;
   } record_type;

   localparam int RECORD_W = $bits(record_type);

   // Outcome of a scan over the table.
   typedef struct packed {
      logic               hit;
      logic [IDX_W-1:0]   hit_idx;
      logic [PID_W-1:0]   hit_pid;
      logic [COUNT_W-1:0] hit_refs;
      logic               free;
      logic [IDX_W-1:0]   free_idx;
   } match_type;

endpackage

`default_nettype wire

// ===== rtl/rkt_ram.sv =====
`default_nettype none

module rkt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Single write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/rkt_match.sv =====
`default_nettype none

module rkt_match (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic                      sample,
   input  wire logic [rkt_pkg::IDX_W-1:0] sample_idx,
   input  wire rkt_pkg::record_type       record,
   input  wire logic [rkt_pkg::KEY_W-1:0] key,
   output rkt_pkg::match_type             result
);

   import rkt_pkg::*;

   logic               hit_ff;
   logic [IDX_W-1:0]   hit_idx_ff;
   logic [PID_W-1:0]   hit_pid_ff;
   logic [COUNT_W-1:0] hit_refs_ff;
   logic               free_ff;
   logic [IDX_W-1:0]   free_idx_ff;
   logic               key_eq;

   // The one key comparator, used once for each slot as it streams past.
   assign key_eq = (record.key == key);

   // Flags: cleared at reset and when a scan begins, set by the first slot that qualifies.
   always_ff @(posedge clock) begin
      if (reset || start) begin
         hit_ff  <= 1'b0;
         free_ff <= 1'b0;
      end else if (sample) begin
         if (record.valid && key_eq && !hit_ff) begin
            hit_ff <= 1'b1;
         end
         if (!record.valid && !free_ff) begin
            free_ff <= 1'b1;
         end
      end
   end

   // Slot details of the first hit and the first free slot.
   always_ff @(posedge clock) begin
      if (sample) begin
         if (record.valid && key_eq && !hit_ff) begin
            hit_idx_ff  <= sample_idx;
            hit_pid_ff  <= record.pid;
            hit_refs_ff <= record.refs;
         end
         if (!record.valid && !free_ff) begin
            free_idx_ff <= sample_idx;
         end
      end
   end

   assign result.hit      = hit_ff;
   assign result.hit_idx  = hit_idx_ff;
   assign result.hit_pid  = hit_pid_ff;
   assign result.hit_refs = hit_refs_ff;
   assign result.free     = free_ff;
   assign result.free_idx = free_idx_ff;

endmodule

`default_nettype wire

// ===== rtl/refcounted_key_table.sv =====
`default_nettype none

// Reference-counted key table.
// Requests arrive on the req_ stream: tuser carries the mode, tdata the key,
// the process id and the starting count. Each request gives exactly one
// response beat on the rsp_ stream with status, pid, count and occupancy.
// A request is taken only while the block is idle. It then reads every slot
// of the record memory once, one slot a cycle through the single read port,
// and a single shared comparator finds the first matching slot and the first
// free one. The EXEC state then applies the update and writes the memory.
// The response register is loaded as the block leaves EXEC, and the block
// takes no new request until then.
// After reset the block clears the valid flag of every slot, one slot a cycle,
// and takes no request until that pass is done.
// The response sits in an output register: the next request is accepted while
// it waits, but that request is not finished until the receiver has taken the
// previous beat, so a stalled receiver stalls the table without loss.

module refcounted_key_table (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // Fields from bit 0 up: key, proc_id, start_count, zero padding.
   input  wire logic [rkt_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // Fields from bit 0 up: mode.
   input  wire logic [rkt_pkg::MODE_W-1:0]        req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // Fields from bit 0 up: found_pid, ref_count, used_entries, zero padding.
   output logic      [rkt_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // Fields from bit 0 up: status, pid_valid.
   output logic      [rkt_pkg::RSP_TUSER_W-1:0]   rsp_tuser
);

   import rkt_pkg::*;

   typedef enum logic [1:0] {
      CLEAR,
      IDLE,
      SCAN,
      EXEC
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [CNT_W-1:0]   occ_ff, occ_in;
   logic               rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]   rd_idx_ff, rd_idx_in;
   logic [MODE_W-1:0]  mode_ff, mode_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [PID_W-1:0]   pid_ff, pid_in;
   logic [COUNT_W-1:0] start_ff, start_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [PID_W-1:0]   rsp_pid_ff, rsp_pid_in;
   logic               rsp_pvalid_ff, rsp_pvalid_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic [USED_W-1:0]  rsp_used_ff, rsp_used_in;

   logic               req_beat;
   logic               out_free;
   logic               scan_start;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   record_type         wr_rec;
   record_type         rd_rec;
   logic [RECORD_W-1:0] rd_word;
   match_type          match;
   logic [COUNT_W-1:0] new_refs;

   // Outcome of the request, worked out from the finished scan.
   logic [STATUS_W-1:0] ex_status;
   logic               ex_pvalid;
   logic [PID_W-1:0]   ex_pid;
   logic [COUNT_W-1:0] ex_count;
   logic               ex_write;
   logic               ex_use_free;
   logic               ex_keep;
   logic               ex_occ_up;
   logic               ex_occ_down;

   assign req_tready = (state_ff == IDLE);
   assign req_beat   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign scan_start = req_beat;

   // Record memory and the scan comparator.
   rkt_ram #(
      .WIDTH (RECORD_W),
      .DEPTH (ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_rec),
      .rd_addr (cnt_ff[IDX_W-1:0]),
      .rd_data (rd_word)
   );

   assign rd_rec = record_type'(rd_word);

   rkt_match u_match (
      .clock      (clock),
      .reset      (reset),
      .start      (scan_start),
      .sample     (rd_vld_ff),
      .sample_idx (rd_idx_ff),
      .record     (rd_rec),
      .key        (key_ff),
      .result     (match)
   );

   // Shared count adder: plus one for increment, minus one otherwise.
   assign new_refs = match.hit_refs +
                     ((mode_ff == MODE_INC) ? COUNT_W'(1) : {COUNT_W{1'b1}});

   // Decision for the request once every slot has been seen.
   always_comb begin
      ex_status   = ST_MISSING;
      ex_pvalid   = 1'b0;
      ex_pid      = '0;
      ex_count    = '0;
      ex_write    = 1'b0;
      ex_use_free = 1'b0;
      ex_keep     = 1'b1;
      ex_occ_up   = 1'b0;
      ex_occ_down = 1'b0;
      unique case (mode_ff)
         MODE_INSERT: begin
            if (match.hit) begin
               ex_status = ST_PRESENT;
            end else if (!match.free) begin
               ex_status = ST_FULL;
            end else begin
               ex_status   = ST_OK;
               ex_write    = 1'b1;
               ex_use_free = 1'b1;
               ex_occ_up   = 1'b1;
            end
         end
         MODE_INC: begin
            if (match.hit) begin
               ex_status = ST_OK;
               ex_write  = 1'b1;
            end
         end
         MODE_DEC: begin
            if (match.hit) begin
               ex_status = ST_OK;
               ex_write  = 1'b1;
               if (new_refs == '0) begin
                  ex_keep     = 1'b0;
                  ex_pvalid   = 1'b1;
                  ex_pid      = match.hit_pid;
                  ex_occ_down = 1'b1;
               end
            end
         end
         MODE_REMOVE: begin
            if (match.hit) begin
               ex_status   = ST_OK;
               ex_write    = 1'b1;
               ex_keep     = 1'b0;
               ex_pvalid   = 1'b1;
               ex_pid      = match.hit_pid;
               ex_occ_down = 1'b1;
            end
         end
         MODE_LOOKUP: begin
            if (match.hit) begin
               ex_status = ST_OK;
               ex_pvalid = 1'b1;
               ex_pid    = match.hit_pid;
               ex_count  = match.hit_refs;
            end
         end
         default: begin
            ex_status = ST_MISSING;
         end
      endcase
   end

   // Memory write: clearing pass after reset, or the update of one slot.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = match.hit_idx;
      wr_rec  = '0;
      unique case (state_ff)
         CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = cnt_ff[IDX_W-1:0];
         end
         EXEC: begin
            wr_en = ex_write && out_free;
            if (ex_use_free) begin
               wr_addr     = match.free_idx;
               wr_rec.refs = start_ff;
               wr_rec.pid  = pid_ff;
            end else begin
               wr_addr     = match.hit_idx;
               wr_rec.refs = new_refs;
               wr_rec.pid  = match.hit_pid;
            end
            wr_rec.valid = ex_keep;
            wr_rec.key   = key_ff;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   // Sequencer next state.
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      occ_in        = occ_ff;
      rd_vld_in     = 1'b0;
      rd_idx_in     = cnt_ff[IDX_W-1:0];
      mode_in       = mode_ff;
      key_in        = key_ff;
      pid_in        = pid_ff;
      start_in      = start_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_pid_in    = rsp_pid_ff;
      rsp_pvalid_in = rsp_pvalid_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_used_in   = rsp_used_ff;
      unique case (state_ff)
         CLEAR: begin
            if (cnt_ff == ENTRIES_CNT - CNT_W'(1)) begin
               state_in = IDLE;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         IDLE: begin
            if (req_beat) begin
               state_in = SCAN;
               cnt_in   = '0;
               mode_in  = req_tuser;
               key_in   = req_tdata[KEY_W-1:0];
               pid_in   = req_tdata[KEY_W +: PID_W];
               start_in = req_tdata[KEY_W+PID_W +: COUNT_W];
            end
         end
         SCAN: begin
            // One slot read a cycle; the last one is sampled as we leave.
            if (cnt_ff == ENTRIES_CNT) begin
               state_in = EXEC;
            end else begin
               rd_vld_in = 1'b1;
               cnt_in    = cnt_ff + CNT_W'(1);
            end
         end
         EXEC: begin
            if (out_free) begin
               state_in = IDLE;
               unique case ({ex_occ_up, ex_occ_down})
                  2'b10:   occ_in = occ_ff + CNT_W'(1);
                  2'b01:   occ_in = occ_ff - CNT_W'(1);
                  default: occ_in = occ_ff;
               endcase
               rsp_valid_in  = 1'b1;
               rsp_status_in = ex_status;
               rsp_pid_in    = ex_pid;
               rsp_pvalid_in = ex_pvalid;
               rsp_count_in  = ex_count;
               rsp_used_in   = USED_W'(occ_in);
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CLEAR;
         cnt_ff       <= '0;
         occ_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         occ_ff       <= occ_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rd_idx_ff     <= rd_idx_in;
      mode_ff       <= mode_in;
      key_ff        <= key_in;
      pid_ff        <= pid_in;
      start_ff      <= start_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pid_ff    <= rsp_pid_in;
      rsp_pvalid_ff <= rsp_pvalid_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_used_ff   <= rsp_used_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'({rsp_used_ff, rsp_count_ff, rsp_pid_ff});
   assign rsp_tuser  = {rsp_pvalid_ff, rsp_status_ff};

   // The table never holds more records than it has slots.
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= ENTRIES_CNT)
      else $error("occupancy above table depth");

   // A request beat is followed by a busy cycle.
   a_busy_after_beat: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> !req_tready)
      else $error("request taken while a scan was due");

   // A reported pid only comes with a successful outcome.
   a_pid_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_pvalid_ff) |-> (rsp_status_ff == ST_OK))
      else $error("pid reported on a failed request");

   // A non-zero count is only reported by a lookup that found its record.
   a_count_pid: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_count_ff != '0)) |-> rsp_pvalid_ff)
      else $error("count reported without a pid");

   // The memory is never written while a scan is reading it.
   a_no_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SCAN) |-> !wr_en)
      else $error("memory write during scan");

endmodule

`default_nettype wire
